// ----- rtl/lrbs_pkg.sv -----
// Shared types and constants for the link reconnect backoff supervisor.
package lrbs_pkg;

	localparam int IDX_W     = 2;
	localparam int TIME_W    = 32;
	localparam int JIT_W     = 4;
	localparam int FAIL_W    = 8;
	localparam int STREAK_W  = 4;
	localparam int BASE_W    = 16;
	localparam int SHIFT_W   = 4;
	localparam int TICKS_W   = 4;
	localparam int BACKOFF_W = BASE_W + (1 << SHIFT_W) - 1;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
	localparam logic [FAIL_W-1:0]   FAIL_MAX   = '1;

	localparam logic [BASE_W-1:0]  RST_COOLDOWN_BASE = 16'd45;
	localparam logic [SHIFT_W-1:0] RST_MAX_SHIFT     = 4'd4;
	localparam logic [TICKS_W-1:0] RST_CONFIRM       = 4'd8;
	localparam logic [TICKS_W-1:0] RST_DISCONNECT    = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COOLDOWN_BASE = 4'd0,
		CFG_MAX_SHIFT     = 4'd1,
		CFG_CONFIRM       = 4'd2,
		CFG_DISCONNECT    = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [BASE_W-1:0]  cooldown_base;
		logic [SHIFT_W-1:0] shift_cap;
		logic [TICKS_W-1:0] confirm_ticks;
		logic [TICKS_W-1:0] disconnect_ticks;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]   retry_time;
		logic [FAIL_W-1:0]   failures;
		logic [STREAK_W-1:0] down_streak;
		logic [STREAK_W-1:0] up_streak;
		logic                last_link;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0]  iface_index;
		logic              link_up;
		logic [TIME_W-1:0] now_seconds;
		logic [JIT_W-1:0]  jitter;
	} tick_t;

	typedef struct packed {
		logic [IDX_W-1:0]  out_index;
		logic              start_reconnect;
		logic              disable_first;
		logic              retry_cleared;
		logic              link_changed;
		logic [FAIL_W-1:0] fail_total;
		logic [TIME_W-1:0] next_retry;
	} result_t;

endpackage

// ----- rtl/lrbs_if.sv -----
// Handshake channel interfaces: poll ticks, results and register writes.
interface lrbs_tick_if import lrbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  iface_index;
	logic              link_up;
	logic [TIME_W-1:0] now_seconds;
	logic [JIT_W-1:0]  jitter;

	modport source(output valid, iface_index, link_up, now_seconds, jitter, input ready);
	modport sink(input valid, iface_index, link_up, now_seconds, jitter, output ready);
endinterface

interface lrbs_result_if import lrbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  out_index;
	logic              start_reconnect;
	logic              disable_first;
	logic              retry_cleared;
	logic              link_changed;
	logic [FAIL_W-1:0] fail_total;
	logic [TIME_W-1:0] next_retry;

	modport source(output valid, out_index, start_reconnect, disable_first, retry_cleared,
		link_changed, fail_total, next_retry, input ready);
	modport sink(input valid, out_index, start_reconnect, disable_first, retry_cleared,
		link_changed, fail_total, next_retry, output ready);
endinterface

interface lrbs_cfg_if import lrbs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] addr;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ----- rtl/lrbs_cfg_regs.sv -----
// Configuration register bank: cooldown base, shift limit and tick thresholds.
module lrbs_cfg_regs import lrbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_addr,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_base    <= RST_COOLDOWN_BASE;
			cfg_q.shift_cap        <= RST_MAX_SHIFT;
			cfg_q.confirm_ticks    <= RST_CONFIRM;
			cfg_q.disconnect_ticks <= RST_DISCONNECT;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_addr))
				CFG_COOLDOWN_BASE: cfg_q.cooldown_base    <= wr_data[BASE_W-1:0];
				CFG_MAX_SHIFT:     cfg_q.shift_cap        <= wr_data[SHIFT_W-1:0];
				CFG_CONFIRM:       cfg_q.confirm_ticks    <= wr_data[TICKS_W-1:0];
				CFG_DISCONNECT:    cfg_q.disconnect_ticks <= wr_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/lrbs_state_file.sv -----
// Per-interface supervisor state: one read port and one write port.
module lrbs_state_file import lrbs_pkg::*; #(
	parameter int NUM_IFACES = 4,
	parameter int ADDR_W     = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_entry,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_entry
);

	entry_t st_q [NUM_IFACES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IFACES; i++) begin
				st_q[i] <= '0;
			end
		end else if (wr_en) begin
			st_q[wr_addr] <= wr_entry;
		end
	end

	assign rd_entry = st_q[rd_addr];

endmodule

// ----- rtl/lrbs_tick_eval.sv -----
// Next-state and result logic for one poll tick of one interface.
module lrbs_tick_eval import lrbs_pkg::*; (
	input  cfg_t    cfg,
	input  tick_t   tk,
	input  entry_t  cur,
	output entry_t  nxt,
	output result_t res
);

	logic [STREAK_W-1:0]  up_inc;
	logic [STREAK_W-1:0]  down_inc;
	logic [FAIL_W-1:0]    fail_inc;
	logic [FAIL_W-1:0]    shift_raw;
	logic [SHIFT_W-1:0]   shift_amt;
	logic [BACKOFF_W-1:0] backoff;
	logic [TIME_W:0]      sched_sum;
	logic [TIME_W-1:0]    sched_time;
	logic                 time_ok;
	logic                 clear_hit;
	logic                 retry_hit;

	assign up_inc   = (cur.up_streak == STREAK_MAX) ? cur.up_streak : cur.up_streak + 1'b1;
	assign down_inc = (cur.down_streak == STREAK_MAX) ? cur.down_streak
		: cur.down_streak + 1'b1;
	assign fail_inc = (cur.failures == FAIL_MAX) ? cur.failures : cur.failures + 1'b1;
	assign time_ok  = tk.now_seconds >= cur.retry_time;

	// fail_inc is never zero here, so the shift is fail_inc-1 capped at the limit
	assign shift_raw = fail_inc - 1'b1;
	assign shift_amt = (shift_raw > FAIL_W'(cfg.shift_cap)) ? cfg.shift_cap
		: shift_raw[SHIFT_W-1:0];
	assign backoff    = BACKOFF_W'(cfg.cooldown_base) << shift_amt;
	assign sched_sum  = (TIME_W+1)'(tk.now_seconds) + (TIME_W+1)'(backoff)
		+ (TIME_W+1)'(tk.jitter);
	assign sched_time = sched_sum[TIME_W] ? '1 : sched_sum[TIME_W-1:0];

	assign clear_hit = tk.link_up && (up_inc >= cfg.confirm_ticks) && time_ok;
	assign retry_hit = !tk.link_up && (down_inc >= cfg.disconnect_ticks) && time_ok;

	always_comb begin
		nxt           = cur;
		nxt.last_link = tk.link_up;
		if (tk.link_up) begin
			nxt.up_streak   = up_inc;
			nxt.down_streak = '0;
			if (clear_hit) begin
				nxt.retry_time = '0;
				nxt.failures   = '0;
			end
		end else begin
			nxt.up_streak   = '0;
			nxt.down_streak = retry_hit ? '0 : down_inc;
			if (retry_hit) begin
				nxt.failures   = fail_inc;
				nxt.retry_time = sched_time;
			end
		end

		res.out_index       = tk.iface_index;
		res.start_reconnect = retry_hit;
		res.disable_first   = retry_hit && (cur.failures != '0);
		res.retry_cleared   = clear_hit && ((cur.failures != '0) || (cur.retry_time != '0));
		res.link_changed    = tk.link_up != cur.last_link;
		res.fail_total      = nxt.failures;
		res.next_retry      = nxt.retry_time;
	end

endmodule

// ----- rtl/link_reconnect_backoff_supervisor_unit.sv -----
// Top level of the link reconnect backoff supervisor.
//
// Usage: every transfer on the tick channel is one poll sample for one
// interface (index, link-up bit, current time in seconds, jitter). For every
// tick exactly one result transfer comes out on the result channel, in order:
// reconnect request, disable-first flag, retry-cleared flag, link-change flag,
// updated failure count and next retry time. The cfg channel writes the four
// registers (0 cooldown base, 1 backoff shift limit, 2 confirm ticks,
// 3 disconnect ticks); it is always ready and should be used while idle.
// The tick passes one input stage and one result stage, with the
// per-interface state read and written between them. Throughput is one
// tick per cycle while results are taken, also for back-to-back ticks on the
// same interface, because the state update lands at the same edge the result
// is registered. When the receiver stalls, the result stage holds and the
// input stage still takes one more tick; then the tick channel backs off.
// Reset clears all interface state and loads the register defaults
// (45, 4, 8, 2). Ticks for an index at or beyond NUM_IFACES leave state
// untouched and return a result with every field but the index at zero.
module link_reconnect_backoff_supervisor_unit import lrbs_pkg::*; #(
	parameter int NUM_IFACES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	lrbs_tick_if.sink     tick,
	lrbs_result_if.source result,
	lrbs_cfg_if.sink      cfg
);

	localparam int ADDR_W = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
	localparam int EXT_W  = 5;

	cfg_t    cfg_cur;
	tick_t   tick_s1;
	logic    vld_s1;
	result_t res_s2;
	logic    vld_s2;

	entry_t  cur_entry;
	entry_t  nxt_entry;
	result_t eval_res;
	result_t res_next;

	logic [EXT_W-1:0]  idx_ext;
	logic [ADDR_W-1:0] addr;
	logic              idx_ok;
	logic              adv_s1;

	// Registers are written whenever the cfg channel offers data.
	assign cfg.ready = 1'b1;

	lrbs_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_addr (cfg.addr),
		.wr_data (cfg.data),
		.cfg     (cfg_cur)
	);

	// Advance stage 1 when the result stage is empty or being drained.
	assign adv_s1     = vld_s1 && (!vld_s2 || result.ready);
	assign tick.ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.iface_index <= tick.iface_index;
			tick_s1.link_up     <= tick.link_up;
			tick_s1.now_seconds <= tick.now_seconds;
			tick_s1.jitter      <= tick.jitter;
		end
	end

	// Map the fixed-width index onto the state file and range check it.
	assign idx_ext = EXT_W'(tick_s1.iface_index);
	assign addr    = idx_ext[ADDR_W-1:0];
	assign idx_ok  = idx_ext < EXT_W'(NUM_IFACES);

	lrbs_state_file #(
		.NUM_IFACES (NUM_IFACES),
		.ADDR_W     (ADDR_W)
	) u_state_file (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (addr),
		.rd_entry (cur_entry),
		.wr_en    (adv_s1 && idx_ok),
		.wr_addr  (addr),
		.wr_entry (nxt_entry)
	);

	lrbs_tick_eval u_tick_eval (
		.cfg (cfg_cur),
		.tk  (tick_s1),
		.cur (cur_entry),
		.nxt (nxt_entry),
		.res (eval_res)
	);

	// Out-of-range ticks report only their index.
	always_comb begin
		if (idx_ok) begin
			res_next = eval_res;
		end else begin
			res_next           = '0;
			res_next.out_index = tick_s1.iface_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (result.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid           = vld_s2;
	assign result.out_index       = res_s2.out_index;
	assign result.start_reconnect = res_s2.start_reconnect;
	assign result.disable_first   = res_s2.disable_first;
	assign result.retry_cleared   = res_s2.retry_cleared;
	assign result.link_changed    = res_s2.link_changed;
	assign result.fail_total      = res_s2.fail_total;
	assign result.next_retry      = res_s2.next_retry;

endmodule

// ----- rtl/lrbs_checker.sv -----
// Port-level checks for the supervisor, bound to the top level.
module lrbs_checker import lrbs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic              start_reconnect,
	input logic              disable_first,
	input logic              retry_cleared,
	input logic [FAIL_W-1:0] fail_total,
	input logic [TIME_W-1:0] next_retry
);

	// disable only ever accompanies a reconnect
	a_disable_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && disable_first |-> start_reconnect)
		else $error("disable_first without start_reconnect");

	// a reconnect always leaves at least one recorded failure
	a_start_counts_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && start_reconnect |-> (fail_total != '0) && !retry_cleared)
		else $error("reconnect with zero failure count or with a clear");

	// a clear leaves no retry state behind
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && retry_cleared |-> (fail_total == '0) && (next_retry == '0))
		else $error("retry clear left state behind");

	// a stalled result holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(fail_total) && $stable(next_retry)
		&& $stable(start_reconnect))
		else $error("stalled result changed");

endmodule

bind link_reconnect_backoff_supervisor_unit lrbs_checker u_lrbs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.start_reconnect (result.start_reconnect),
	.disable_first   (result.disable_first),
	.retry_cleared   (result.retry_cleared),
	.fail_total      (result.fail_total),
	.next_retry      (result.next_retry)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the link reconnect backoff supervisor.
module tb;
	import lrbs_pkg::*;

	// Tracks per-interface retry state the same way the block does. Every tick
	// transfer computes one expected verdict, and every result transfer is
	// checked against the oldest one still owed.
	class backoff_scoreboard;
		cfg_t                cfg;
		logic [TIME_W-1:0]   retry_at [4];
		logic [FAIL_W-1:0]   fails [4];
		logic [STREAK_W-1:0] down_run [4];
		logic [STREAK_W-1:0] up_run [4];
		logic                last_up [4];
		result_t             pending_verdicts [$];
		int unsigned         errors;
		int unsigned         ticks_seen;
		int unsigned         reconnects;
		int unsigned         clears;

		function new();
			cfg = '{RST_COOLDOWN_BASE, RST_MAX_SHIFT, RST_CONFIRM, RST_DISCONNECT};
			for (int i = 0; i < 4; i++) begin
				retry_at[i] = '0;
				fails[i] = '0;
				down_run[i] = '0;
				up_run[i] = '0;
				last_up[i] = 1'b0;
			end
			errors = 0;
			ticks_seen = 0;
			reconnects = 0;
			clears = 0;
		endfunction

		function result_t predict_tick(tick_t t);
			result_t     r;
			int unsigned i;
			int unsigned sh;
			logic [63:0] sum;
			i = t.iface_index;
			r = '0;
			r.out_index = t.iface_index;
			r.link_changed = (t.link_up != last_up[i]);
			last_up[i] = t.link_up;
			if (t.link_up) begin
				if (up_run[i] != STREAK_MAX)
					up_run[i]++;
				if (up_run[i] >= cfg.confirm_ticks && t.now_seconds >= retry_at[i]) begin
					r.retry_cleared = (fails[i] != '0) || (retry_at[i] != '0);
					retry_at[i] = '0;
					fails[i] = '0;
				end
				down_run[i] = '0;
			end else begin
				up_run[i] = '0;
				if (down_run[i] != STREAK_MAX)
					down_run[i]++;
				if (down_run[i] >= cfg.disconnect_ticks && t.now_seconds >= retry_at[i]) begin
					r.start_reconnect = 1'b1;
					r.disable_first = (fails[i] != '0);
					if (fails[i] != FAIL_MAX)
						fails[i]++;
					sh = fails[i] - 1;
					if (sh > cfg.shift_cap)
						sh = cfg.shift_cap;
					sum = 64'(t.now_seconds) + (64'(cfg.cooldown_base) << sh) + 64'(t.jitter);
					retry_at[i] = (sum > 64'hFFFF_FFFF) ? '1 : sum[TIME_W-1:0];
					down_run[i] = '0;
				end
			end
			r.fail_total = fails[i];
			r.next_retry = retry_at[i];
			return r;
		endfunction

		function void note_tick(tick_t t);
			result_t r;
			r = predict_tick(t);
			ticks_seen++;
			if (r.start_reconnect)
				reconnects++;
			if (r.retry_cleared)
				clears++;
			pending_verdicts.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_verdicts.size() == 0) begin
				$error("result transfer with no tick outstanding (index %0d)", got.out_index);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			compare_field("out_index", want.out_index, got.out_index);
			compare_field("start_reconnect", want.start_reconnect, got.start_reconnect);
			compare_field("disable_first", want.disable_first, got.disable_first);
			compare_field("retry_cleared", want.retry_cleared, got.retry_cleared);
			compare_field("link_changed", want.link_changed, got.link_changed);
			compare_field("fail_total", want.fail_total, got.fail_total);
			compare_field("next_retry", want.next_retry, got.next_retry);
		endfunction

		function int unsigned outstanding();
			return pending_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lrbs_tick_if   tk ();
	lrbs_result_if res ();
	lrbs_cfg_if    cf ();

	link_reconnect_backoff_supervisor_unit #(.NUM_IFACES(4)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tk),
		.result (res),
		.cfg    (cf)
	);

	backoff_scoreboard sb;

	// Knobs shared between the sender, the receiver and the phase sequencer.
	bit          idle_on;
	int unsigned hold_req;
	int unsigned stall_left;
	int unsigned settings_used;
	logic        trend [4];
	result_t     seen;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run (about 1000 ticks, each
	// with a full sender gap and a full receiver stall, plus the long hold).
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: one ready assignment per edge. A pending long hold starts once
	// any running stall has ended and takes priority over a new short random stall.
	initial begin
		stall_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (hold_req > 0) begin
				stall_left = hold_req - 1;
				hold_req = 0;
				res.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Monitor: pick up every result transfer with the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			seen.out_index       = res.out_index;
			seen.start_reconnect = res.start_reconnect;
			seen.disable_first   = res.disable_first;
			seen.retry_cleared   = res.retry_cleared;
			seen.link_changed    = res.link_changed;
			seen.fail_total      = res.fail_total;
			seen.next_retry      = res.next_retry;
			sb.check_result(seen);
		end
	end

	// Offer one tick, optionally after a short random gap, and hold it until
	// the transfer. Valid stays high on return so the next tick can follow
	// back to back.
	task automatic send_tick(tick_t t);
		int unsigned gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
		if (gap != 0) begin
			tk.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tk.valid       <= 1'b1;
		tk.iface_index <= t.iface_index;
		tk.link_up     <= t.link_up;
		tk.now_seconds <= t.now_seconds;
		tk.jitter      <= t.jitter;
		do
			@(posedge clk);
		while (!tk.ready);
		sb.note_tick(t);
	endtask

	task automatic tick(int unsigned idx, bit up, logic [TIME_W-1:0] now, int unsigned jit);
		tick_t t;
		t.iface_index = IDX_W'(idx);
		t.link_up     = up;
		t.now_seconds = now;
		t.jitter      = JIT_W'(jit);
		send_tick(t);
	endtask

	// Drop valid and wait until every owed result has arrived, then let the
	// two-stage pipe settle.
	task automatic drain();
		tk.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers back to back; only called while the block is idle.
	task automatic load_config(cfg_t c);
		cfg_reg_t             r;
		logic [CFG_DAT_W-1:0] d;
		for (int k = 0; k < 4; k++) begin
			r = cfg_reg_t'(k);
			case (r)
				CFG_COOLDOWN_BASE: d = c.cooldown_base;
				CFG_MAX_SHIFT:     d = CFG_DAT_W'(c.shift_cap);
				CFG_CONFIRM:       d = CFG_DAT_W'(c.confirm_ticks);
				default:           d = CFG_DAT_W'(c.disconnect_ticks);
			endcase
			cf.valid <= 1'b1;
			cf.addr  <= r;
			cf.data  <= d;
			do
				@(posedge clk);
			while (!cf.ready);
		end
		cf.valid <= 1'b0;
		sb.cfg = c;
		settings_used++;
	endtask

	// Pick a poll time near the interface's retry time, so that about half the
	// picked times land at or just after the point where a reconnect is allowed again.
	function automatic logic [TIME_W-1:0] pick_time(int unsigned idx);
		logic [TIME_W:0] s;
		case ($urandom_range(0, 3))
			0, 1: begin
				s = {1'b0, sb.retry_at[idx]} + $urandom_range(0, 3);
				return s[TIME_W] ? '1 : s[TIME_W-1:0];
			end
			2: begin
				if (sb.retry_at[idx] >= 20)
					return sb.retry_at[idx] - $urandom_range(1, 20);
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	// Random ticks: mostly runs of up or down per interface with times near
	// the retry point, with some fully random noise ticks mixed in.
	task automatic run_random(int unsigned n);
		int unsigned idx;
		for (int k = 0; k < n; k++) begin
			idx = $urandom_range(0, 3);
			if ($urandom_range(0, 9) == 0) begin
				tick(idx, 1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 15));
			end else begin
				if ($urandom_range(0, 9) == 0)
					trend[idx] = ~trend[idx];
				tick(idx, trend[idx], pick_time(idx), $urandom_range(0, 15));
			end
		end
	endtask

	initial begin
		cfg_t c;
		sb = new();
		idle_on = 1'b1;
		hold_req = 0;
		settings_used = 1;
		for (int i = 0; i < 4; i++)
			trend[i] = 1'($urandom_range(0, 1));

		// Hold every input at a known value through reset.
		arst_n         <= 1'b0;
		tk.valid       <= 1'b0;
		tk.iface_index <= '0;
		tk.link_up     <= 1'b0;
		tk.now_seconds <= '0;
		tk.jitter      <= '0;
		cf.valid       <= 1'b0;
		cf.addr        <= CFG_COOLDOWN_BASE;
		cf.data        <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under the reset settings (45, 4, 8, 2).
		// First reconnect on interface 0: no earlier failure, so no disable.
		tick(0, 0, 0, 0);
		tick(0, 0, 0, 15);
		// Still inside the backoff window: streak builds but nothing starts.
		tick(0, 0, 10, 3);
		// Second reconnect right at the retry time: disable first, doubled backoff.
		tick(0, 0, sb.retry_at[0], 7);
		// Stable link with nothing to clear: the clear flag must stay low.
		for (int k = 0; k < 8; k++)
			tick(1, 1, 0, 0);
		// Stable link at the top of time: eighth up tick clears the retry state.
		for (int k = 0; k < 8; k++)
			tick(0, 1, '1, 15);
		// Reconnect close to the end of time: the retry time saturates.
		tick(2, 0, 32'hFFFF_FFF0, 15);
		tick(2, 0, 32'hFFFF_FFF0, 15);
		// Link toggles on a fresh interface.
		tick(3, 1, 32'h8000_0000, 0);
		tick(3, 0, 32'h7FFF_FFFF, 0);

		run_random(100);
		drain();

		// Zero base and zero thresholds: every tick meets its streak threshold.
		c = '{16'd0, 4'd0, 4'd0, 4'd0};
		load_config(c);
		run_random(80);
		drain();

		// Top of every register range, including saturating down and up streaks.
		c = '{16'hFFFF, 4'd15, 4'd15, 4'd15};
		load_config(c);
		run_random(100);
		drain();

		// Long receiver hold while the sender keeps offering: the block must
		// fill up and back off its tick channel.
		c = '{16'd1, 4'd15, 4'd1, 4'd1};
		load_config(c);
		idle_on = 1'b0;
		hold_req = 60;
		run_random(100);
		drain();
		idle_on = 1'b1;

		// Failure count saturation: back-to-back reconnects on one interface.
		c = '{16'd1, 4'd0, 4'd15, 4'd1};
		load_config(c);
		for (int k = 0; k < 270; k++)
			tick(0, 0, sb.retry_at[0], $urandom_range(0, 15));
		drain();

		// Random register values.
		c.cooldown_base    = BASE_W'($urandom_range(1, 65535));
		c.shift_cap        = SHIFT_W'($urandom_range(0, 15));
		c.confirm_ticks    = TICKS_W'($urandom_range(1, 15));
		c.disconnect_ticks = TICKS_W'($urandom_range(1, 15));
		load_config(c);
		run_random(150);
		drain();

		// Final stretch at full rate on both sides.
		c = '{16'd300, 4'd3, 4'd4, 4'd3};
		load_config(c);
		idle_on = 1'b0;
		run_random(130);
		drain();

		$display("Run covered %0d ticks under %0d register settings.",
			sb.ticks_seen, settings_used);
		$display("Reconnects started: %0d, retry states cleared: %0d.",
			sb.reconnects, sb.clears);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
